// ----- hw/rtl/csmv_pkg.sv -----
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types and constants for the sparse matrix-vector core: action
// codes, default sizes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package csmv_pkg;

    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 64;

    localparam int IDX_W  = 6;
    localparam int WORD_W = 32;

    typedef logic [1:0] t_action;

    localparam t_action ACT_LOAD    = 2'd0;
    localparam t_action ACT_NONZERO = 2'd1;
    localparam t_action ACT_FINISH  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;    // register the accepted item
        logic vec_wr;     // write vector element
        logic mem_rd;     // read vector[col] and accumulator[row]
        logic mul_en;     // register value * vector element
        logic acc_wr;     // write back accumulator[row]
        logic sweep_clr;  // restart the row counter
        logic sweep_rd;   // read accumulator at the row counter
        logic out_load;   // move swept sum into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_action action;
        logic    ld_ok;       // load column within the vector
        logic    nz_ok;       // nonzero row and column in range
        logic    sweep_last;  // row counter at the final row
        logic    out_free;    // output register can take a transfer
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/csmv_ctrl.sv -----
// ----------------------------------------------------------------------------
// csmv_ctrl
// Controller state machine: sequences load, multiply-accumulate and the
// finish sweep over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module csmv_ctrl import csmv_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_accept,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_NZ_MUL = 3'd2;
    localparam logic [2:0] S_NZ_WR  = 3'd3;
    localparam logic [2:0] S_FIN_RD = 3'd4;
    localparam logic [2:0] S_FIN_OUT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_accept;
                if (i_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_sts.action == ACT_LOAD) begin
                    o_cmd.vec_wr = i_sts.ld_ok;
                    n_state      = S_IDLE;
                end else if (i_sts.action == ACT_NONZERO && i_sts.nz_ok) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_NZ_MUL;
                end else if (i_sts.action == ACT_FINISH) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = S_FIN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NZ_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_NZ_WR;
            end
            S_NZ_WR: begin
                o_cmd.acc_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_FIN_RD: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.sweep_last ? S_IDLE : S_FIN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/csmv_dpath.sv -----
// ----------------------------------------------------------------------------
// csmv_dpath
// Datapath: vector store, row accumulator memory with valid bits,
// multiplier, adder, sweep counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csmv_dpath import csmv_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  wire  [1:0]          i_action,
    input  wire  [IDX_W-1:0]    i_row,
    input  wire  [IDX_W-1:0]    i_col,
    input  wire  [WORD_W-1:0]   i_value,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output logic [IDX_W-1:0]    o_out_row,
    output logic [WORD_W-1:0]   o_out_sum,
    output logic                o_out_last
);

    localparam int VEC_DEPTH = (COLS < (1 << IDX_W)) ? COLS : (1 << IDX_W);
    localparam int VW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [WORD_W-1:0] vec_mem [VEC_DEPTH];
    logic [WORD_W-1:0] acc_mem [ROWS];
    logic [ROWS-1:0]   r_acc_vld;

    t_action           r_action;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [WORD_W-1:0] r_val;
    logic [WORD_W-1:0] r_vec_rd;
    logic [WORD_W-1:0] r_acc_rd;
    logic              r_acc_rd_vld;
    logic [WORD_W-1:0] r_prod;
    logic [RW-1:0]     r_cnt;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_row;
    logic [WORD_W-1:0] r_out_sum;
    logic              r_out_last;

    logic [RW-1:0]     acc_addr;
    logic [RW-1:0]     row_addr;
    logic [VW-1:0]     col_addr;
    logic [WORD_W-1:0] acc_old;
    logic              cnt_last;

    assign row_addr = r_row[RW-1:0];
    assign col_addr = r_col[VW-1:0];
    assign acc_addr = i_cmd.sweep_rd ? r_cnt : row_addr;
    assign acc_old  = r_acc_rd_vld ? r_acc_rd : '0;
    assign cnt_last = (32'(r_cnt) == ROWS - 1);

    assign o_sts.action     = r_action;
    assign o_sts.ld_ok      = (13'(r_col) < 13'(COLS));
    assign o_sts.nz_ok      = (13'(r_col) < 13'(COLS)) && (7'(r_row) < 7'(ROWS));
    assign o_sts.sweep_last = cnt_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Item capture and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_row    <= i_row;
            r_col    <= i_col;
            r_val    <= i_value;
        end
        if (i_cmd.mul_en) begin
            r_prod <= WORD_W'(r_val * r_vec_rd);
        end
    end

    // Vector store
    always_ff @(posedge i_clk) begin
        if (i_cmd.vec_wr) begin
            vec_mem[col_addr] <= r_val;
        end
        if (i_cmd.mem_rd) begin
            r_vec_rd <= vec_mem[col_addr];
        end
    end

    // Accumulator memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_wr) begin
            acc_mem[row_addr] <= acc_old + r_prod;
        end
        if (i_cmd.mem_rd || i_cmd.sweep_rd) begin
            r_acc_rd <= acc_mem[acc_addr];
        end
    end

    // Valid bits: an unmarked row reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld    <= '0;
            r_acc_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.acc_wr) begin
                r_acc_vld[row_addr] <= 1'b1;
            end else if (i_cmd.out_load) begin
                r_acc_vld[r_cnt] <= 1'b0;
            end
            if (i_cmd.mem_rd || i_cmd.sweep_rd) begin
                r_acc_rd_vld <= r_acc_vld[acc_addr];
            end
        end
    end

    // Sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.out_load) begin
            r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= IDX_W'(r_cnt);
            r_out_sum  <= acc_old;
            r_out_last <= cnt_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_sum   = r_out_sum;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/coo_sparse_matvec_core.sv -----
// ----------------------------------------------------------------------------
// coo_sparse_matvec_core
// Sparse matrix times dense vector, matrix streamed as coordinate triples.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per transfer. tuser carries the action (load
//   vector element, nonzero triple, finish); tdata carries row, column and
//   value. Master channel: one row sum per transfer, rows 0 to ROWS-1 in
//   order after a finish, tlast on the final row.
// Sequencing:
//   The block takes one item at a time; tready is high only when idle.
//   A load steps through capture and vector write. A nonzero steps
//   through capture, vector and accumulator read, registered multiply and
//   accumulator write back. An out-of-range or unknown item is captured
//   and then discarded. A finish clears the row counter, and each row needs
//   one accumulator memory read before it enters the output register. The
//   row 0 sum is offered after the dispatch, read and output-load states.
// Reset:
//   Synchronous, active low. Accumulators read as zero through per-row
//   valid bits cleared at reset; no clearing pass. Vector store unset.
// Stall:
//   The sweep holds while the output register is full and not taken. The
//   final sum may wait in the output register while the next item is
//   accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_sparse_matvec_core import csmv_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,   // row_index[5:0], col_index[11:6], value[43:12], zero pad
    input  wire  [1:0]  i_s_tuser,   // action[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,   // out_row[5:0], sum[37:6], zero pad
    output logic        o_m_tlast    // last
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              accept;
    logic [IDX_W-1:0]  out_row;
    logic [WORD_W-1:0] out_sum;

    // Accept a transfer only when the controller is idle
    assign accept = i_s_tvalid && o_s_tready;

    csmv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_ready  (o_s_tready),
        .o_cmd    (cmd)
    );

    csmv_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_s_tuser),
        .i_row       (i_s_tdata[5:0]),
        .i_col       (i_s_tdata[11:6]),
        .i_value     (i_s_tdata[43:12]),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_row   (out_row),
        .o_out_sum   (out_sum),
        .o_out_last  (o_m_tlast)
    );

    // Pack the result: row in the low bits, sum above, pad to whole bytes
    assign o_m_tdata = {2'b00, out_sum, out_row};

    // Slave tready is low straight after every accepted transfer
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready
    ) else $error("slave tready high straight after an accepted transfer");

    // The marked result always belongs to the final row
    a_last_row: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[5:0] == IDX_W'(ROWS - 1))
    ) else $error("tlast on a row other than the final one");

    // Hold the offered sum steady while the receiver stalls
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    ) else $error("master transfer changed while stalled");

    // No sweep result while the block is idle with an empty output
    a_no_spurious_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && !o_m_tvalid) |=> !o_m_tvalid
    ) else $error("result appeared without a finish item");

endmodule

`default_nettype wire
